/* src/atilt_pkg.sv */
// Shared types and constants for the accelerometer tilt block.
`timescale 1ns / 1ps
package atilt_pkg;

  localparam int unsigned TableLen = 24;
  localparam int unsigned AccW = 26;
  localparam logic [AccW-1:0] QuarterAcc = 26'd5898240;
  localparam logic [15:0] QuarterOut = 16'd11520;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_CORDIC,
    ST_NEXT,
    ST_MEAN,
    ST_OUT
  } state_t;

  function automatic logic [AccW-1:0] atan_step(input logic [4:0] i);
    logic [AccW-1:0] r;
    begin
      unique case (i)
        5'd0: r = 26'd2949120;
        5'd1: r = 26'd1740967;
        5'd2: r = 26'd919879;
        5'd3: r = 26'd466945;
        5'd4: r = 26'd234379;
        5'd5: r = 26'd117304;
        5'd6: r = 26'd58666;
        5'd7: r = 26'd29335;
        5'd8: r = 26'd14668;
        5'd9: r = 26'd7334;
        5'd10: r = 26'd3667;
        5'd11: r = 26'd1833;
        5'd12: r = 26'd917;
        5'd13: r = 26'd458;
        5'd14: r = 26'd229;
        5'd15: r = 26'd115;
        5'd16: r = 26'd57;
        5'd17: r = 26'd29;
        5'd18: r = 26'd14;
        5'd19: r = 26'd7;
        5'd20: r = 26'd4;
        5'd21: r = 26'd2;
        5'd22: r = 26'd1;
        default: r = 26'd0;
      endcase
      return r;
    end
  endfunction

endpackage

/* src/accel_tilt_angles_with_offset_cal.sv */
// Top level of the accelerometer tilt angle block with offset calibration.
//
// One input item on s_axis carries a three-axis sample and a calibration flag
// in tuser. One result item on m_axis carries three tilt angles in 1/128 degree
// after subtraction of the stored offsets, and calibration_done in tuser.
// Each axis in turn goes through a square root unit that settles one root bit
// per cycle, a shared CORDIC vectoring unit doing one iteration per cycle and
// a state that stores the angle. The item that completes calibration then
// passes through a serial divider that forms each of the three means in turn.
// One item is in flight at a time; s_axis_tready is high only while idle, so
// a new item is taken only after the last result has been taken. The result is
// held in the output register until taken, so a stalled receiver simply holds
// the block. Reset clears offsets, sums and the count.
`timescale 1ns / 1ps
module accel_tilt_angles_with_offset_cal #(
  parameter int unsigned CAL_SAMPLES = 100,
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // pitch_angle, roll_angle, z_tilt_angle
  output logic        m_axis_tuser    // calibration_done
);

  localparam int unsigned Aw = atilt_pkg::AccW;
  localparam int unsigned Iters =
    (CORDIC_ITERATIONS < atilt_pkg::TableLen) ? CORDIC_ITERATIONS : atilt_pkg::TableLen;
  localparam int unsigned XW = 36;

  atilt_pkg::state_t state, state_next;

  logic        op;
  logic signed [15:0] ax [3];
  logic [1:0]  axis;
  logic [31:0] rem;
  logic [31:0] root;
  logic [31:0] sq_sh;
  logic [5:0]  sq_cnt;
  logic signed [XW-1:0] cx, cy;
  logic signed [Aw:0] cz;
  logic [4:0]  it;
  logic signed [14:0] offs [3];
  logic signed [21:0] sums [3];
  logic [6:0]  cal_count;
  logic        done;
  logic [1:0]  mi;
  logic [4:0]  dcnt;
  logic [21:0] dq, drem;
  logic [47:0] out_data;

  logic signed [15:0] a_cur, b_cur, c_cur;
  logic signed [31:0] b_ext, c_ext;
  logic [31:0] ss;
  logic [33:0] rem_sh;
  logic [33:0] sq_trial;
  logic signed [XW-1:0] dx, dy;
  logic signed [Aw:0] zc;
  logic [15:0] mag;
  logic signed [15:0] tval;
  logic signed [21:0] sum_m;
  logic [21:0] mag_s;
  logic [22:0] dtrial;

  always_comb begin
    a_cur = ax[axis];
    unique case (axis)
      2'd0: begin b_cur = ax[1]; c_cur = ax[2]; end
      2'd1: begin b_cur = ax[0]; c_cur = ax[2]; end
      default: begin b_cur = ax[0]; c_cur = ax[1]; end
    endcase
    b_ext = 32'(b_cur);
    c_ext = 32'(c_cur);
    ss = 32'(b_ext * b_ext) + 32'(c_ext * c_ext);
    rem_sh = {rem, sq_sh[31:30]};
    sq_trial = {root, 2'b01};
    dx = cy >>> it;
    dy = cx >>> it;
    if (cz < 0) zc = '0;
    else if (cz > $signed({1'b0, atilt_pkg::QuarterAcc})) zc = {1'b0, atilt_pkg::QuarterAcc};
    else zc = cz;
    mag = 16'((zc + 27'sd256) >>> 9);
    if (a_cur == 0) tval = '0;
    else if (ss == 0) tval = a_cur[15] ? -$signed(atilt_pkg::QuarterOut)
                                       : $signed(atilt_pkg::QuarterOut);
    else tval = a_cur[15] ? -$signed(mag) : $signed(mag);
    sum_m = sums[mi];
    mag_s = sum_m[21] ? 22'(-sum_m) : 22'(sum_m);
    dtrial = {drem, dq[21]} - 23'(CAL_SAMPLES);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      atilt_pkg::ST_IDLE:   if (s_axis_tvalid) state_next = atilt_pkg::ST_SQRT;
      atilt_pkg::ST_SQRT:   if (sq_cnt == 6'd33) state_next = atilt_pkg::ST_CORDIC;
      atilt_pkg::ST_CORDIC: if (it == 5'(Iters)) state_next = atilt_pkg::ST_NEXT;
      atilt_pkg::ST_NEXT: begin
        if (axis != 2'd2) state_next = atilt_pkg::ST_SQRT;
        else if (op && (cal_count + 7'd1 >= 7'(CAL_SAMPLES))) state_next = atilt_pkg::ST_MEAN;
        else state_next = atilt_pkg::ST_OUT;
      end
      atilt_pkg::ST_MEAN:
        if (mi == 2'd2 && dcnt == 5'd23) state_next = atilt_pkg::ST_OUT;
      atilt_pkg::ST_OUT:    if (m_axis_tready) state_next = atilt_pkg::ST_IDLE;
      default: state_next = atilt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == atilt_pkg::ST_IDLE);
    m_axis_tvalid = (state == atilt_pkg::ST_OUT);
    m_axis_tdata = out_data;
    m_axis_tuser = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atilt_pkg::ST_IDLE;
      cal_count <= '0;
      done <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        offs[k] <= '0;
        sums[k] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        atilt_pkg::ST_IDLE: if (s_axis_tvalid) begin
          op <= s_axis_tuser;
          ax[0] <= s_axis_tdata[15:0];
          ax[1] <= s_axis_tdata[31:16];
          ax[2] <= s_axis_tdata[47:32];
          axis <= '0;
          sq_cnt <= '0;
          done <= 1'b0;
        end
        atilt_pkg::ST_SQRT: begin
          if (sq_cnt == 6'd0) begin
            sq_sh <= ss;
            rem <= '0;
            root <= '0;
            sq_cnt <= 6'd1;
          end else if (sq_cnt != 6'd33) begin
            if (rem_sh >= sq_trial) begin
              rem <= 32'(rem_sh - sq_trial);
              root <= {root[30:0], 1'b1};
            end else begin
              rem <= rem_sh[31:0];
              root <= {root[30:0], 1'b0};
            end
            sq_sh <= {sq_sh[29:0], 2'b00};
            sq_cnt <= sq_cnt + 6'd1;
          end else begin
            cx <= XW'(root);
            cy <= XW'({a_cur[15] ? 16'(-a_cur) : 16'(a_cur), 16'd0});
            cz <= '0;
            it <= '0;
          end
        end
        atilt_pkg::ST_CORDIC: if (it != 5'(Iters)) begin
          if (cy >= 0) begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + $signed({1'b0, atilt_pkg::atan_step(it)});
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - $signed({1'b0, atilt_pkg::atan_step(it)});
          end
          it <= it + 5'd1;
        end
        atilt_pkg::ST_NEXT: begin
          out_data[16*axis +: 16] <= tval - 16'(offs[axis]);
          if (op) sums[axis] <= sums[axis] + 22'(tval);
          axis <= axis + 2'd1;
          sq_cnt <= '0;
          if (axis == 2'd2 && op) begin
            if (cal_count + 7'd1 >= 7'(CAL_SAMPLES)) begin
              cal_count <= '0;
              done <= 1'b1;
              mi <= '0;
              dcnt <= '0;
            end else begin
              cal_count <= cal_count + 7'd1;
            end
          end
        end
        atilt_pkg::ST_MEAN: begin
          if (dcnt == 5'd0) begin
            dq <= mag_s + 22'(CAL_SAMPLES / 2);
            drem <= '0;
            dcnt <= 5'd1;
          end else if (dcnt != 5'd23) begin
            if (!dtrial[22]) begin
              drem <= dtrial[21:0];
              dq <= {dq[20:0], 1'b1};
            end else begin
              drem <= {drem[20:0], dq[21]};
              dq <= {dq[20:0], 1'b0};
            end
            dcnt <= dcnt + 5'd1;
          end else begin
            offs[mi] <= sum_m[21] ? -$signed(dq[14:0]) : $signed(dq[14:0]);
            sums[mi] <= '0;
            mi <= mi + 2'd1;
            dcnt <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* src/atilt_checker.sv */
// Port-level checker for the accelerometer tilt block, with its bind.
`timescale 1ns / 1ps
module atilt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("accepting while result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("item not in progress after accept");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result after reset");

endmodule

bind accel_tilt_angles_with_offset_cal atilt_checker u_atilt_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

/* tb/tb.sv */
// Testbench for the accelerometer tilt angle block with offset calibration.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned CalSamples = 100;
  localparam int unsigned CordicIters = 16;
  localparam int unsigned Quarter = 11520;
  localparam longint unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic               cal;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] ztilt;
    logic               done;
  } angles_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  sample_t sample_q[$];
  angles_t angles_q[$];

  int signed pitch_off = 0, roll_off = 0, ztilt_off = 0;
  int signed pitch_acc = 0, roll_acc = 0, ztilt_acc = 0;
  int unsigned cal_seen = 0;
  int unsigned n_errors = 0, n_results = 0, n_cal_done = 0, n_sent = 0;
  longint unsigned cycle = 0;
  logic    calm;
  int      src_gap, snk_gap, hold_cycles;
  bit      hold_req;

  accel_tilt_angles_with_offset_cal #(
    .CAL_SAMPLES(CalSamples),
    .CORDIC_ITERATIONS(CordicIters)
  ) i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint signed atan_deg(input int i);
    longint signed steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
      58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
      4, 2, 1, 0};
    return steps[i];
  endfunction

  function automatic int signed tilt_angle(input int signed a, input int signed b,
                                           input int signed c);
    longint signed s, x, y, z, dx, dy;
    int signed res;
    s = longint'(b) * b + longint'(c) * c;
    z = 0;
    if (a == 0) return 0;
    if (s == 0) return (a > 0) ? Quarter : -Quarter;
    x = longint'(int_sqrt(longint'(s) << 32));
    y = longint'(a < 0 ? -a : a) * 65536;
    for (int i = 0; i < CordicIters && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += atan_deg(i);
      end else begin
        x -= dx;
        y += dy;
        z -= atan_deg(i);
      end
    end
    if (z < 0) z = 0;
    if (z > 5898240) z = 5898240;
    res = int'((z + 256) >>> 9);
    return (a < 0) ? -res : res;
  endfunction

  function automatic int signed mean_of(input int signed sum);
    int signed mag, q;
    mag = (sum < 0) ? -sum : sum;
    q = (mag + CalSamples / 2) / CalSamples;
    return (sum < 0) ? -q : q;
  endfunction

  task automatic predict_angles(input sample_t smp);
    int signed tp, tr, tz;
    angles_t e;
    tp = tilt_angle(smp.ax, smp.ay, smp.az);
    tr = tilt_angle(smp.ay, smp.ax, smp.az);
    tz = tilt_angle(smp.az, smp.ax, smp.ay);
    e.pitch = 16'(tp - pitch_off);
    e.roll = 16'(tr - roll_off);
    e.ztilt = 16'(tz - ztilt_off);
    e.done = 1'b0;
    if (smp.cal) begin
      pitch_acc += tp;
      roll_acc += tr;
      ztilt_acc += tz;
      cal_seen++;
      if (cal_seen >= CalSamples) begin
        pitch_off = mean_of(pitch_acc);
        roll_off = mean_of(roll_acc);
        ztilt_off = mean_of(ztilt_acc);
        pitch_acc = 0;
        roll_acc = 0;
        ztilt_acc = 0;
        cal_seen = 0;
        e.done = 1'b1;
      end
    end
    angles_q.push_back(e);
  endtask

  // Sender: idles in random bursts while calm is low.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_angles(sample_q.pop_front());
        n_sent <= n_sent + 1;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          src_gap <= $urandom_range(1, 13);
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          sample_t nxt;
          nxt = sample_q[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {nxt.az, nxt.ay, nxt.ax};
          s_axis_tuser <= nxt.cal;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      snk_gap <= 0;
      hold_cycles <= 0;
    end else if (hold_req && hold_cycles == 0 && snk_gap == 0) begin
      hold_cycles <= 2000;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 1) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      snk_gap <= $urandom_range(1, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor and checker.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      angles_t got, want;
      got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32], m_axis_tuser};
      n_results++;
      if (got.done) n_cal_done++;
      if (angles_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("Unexpected result item %h", got);
      end else begin
        want = angles_q.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("Mismatch: expected p=%0d r=%0d z=%0d d=%0b, got p=%0d r=%0d z=%0d d=%0b",
                     want.pitch, want.roll, want.ztilt, want.done,
                     got.pitch, got.roll, got.ztilt, got.done);
        end
      end
    end
    if (cycle >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycle);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [15:0] axis_value(input int mode);
    case (mode)
      0: return 16'sd0;
      1: return 16'(signed'($urandom_range(0, 200)) - 100);
      2: return 16'(signed'($urandom_range(0, 16)) - 8);
      3: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t random_sample(input logic cal);
    sample_t smp;
    smp.cal = cal;
    smp.ax = axis_value($urandom_range(0, 9) < 1 ? $urandom_range(0, 3) : 4);
    smp.ay = axis_value($urandom_range(0, 9) < 1 ? $urandom_range(0, 3) : 4);
    smp.az = axis_value($urandom_range(0, 9) < 1 ? $urandom_range(0, 3) : 4);
    return smp;
  endfunction

  task automatic add_sample(input logic cal, input int x, input int y, input int z);
    sample_t smp;
    smp.cal = cal;
    smp.ax = 16'(x);
    smp.ay = 16'(y);
    smp.az = 16'(z);
    sample_q.push_back(smp);
  endtask

  initial begin
    int n_stim;
    rst = 1'b1;
    calm = 1'b0;
    hold_req = 1'b0;

    // Directed: zeros, zero denominators, extremes, ones and tiny values.
    add_sample(1'b0, 0, 0, 0);
    add_sample(1'b0, 100, 0, 0);
    add_sample(1'b0, 0, -100, 0);
    add_sample(1'b0, 0, 0, 32767);
    add_sample(1'b0, -32768, 0, 0);
    add_sample(1'b0, 32767, 32767, 32767);
    add_sample(1'b0, -32768, -32768, -32768);
    add_sample(1'b0, 32767, -32768, 1);
    add_sample(1'b0, 1, 1, 1);
    add_sample(1'b0, -1, 1, -1);
    add_sample(1'b0, 0, 8192, 8192);
    add_sample(1'b0, 8192, 0, 0);
    add_sample(1'b0, 1, 32767, -32768);
    add_sample(1'b0, 16'h5555, 16'haaaa, 16'h5555);
    add_sample(1'b1, 1000, -2000, 8000);
    add_sample(1'b1, 0, 0, 0);
    add_sample(1'b0, -1, -1, -1);
    add_sample(1'b0, 12345, -23456, 4321);
    n_stim = sample_q.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Mostly calibration runs so that offsets become non-zero.
    while (n_stim < 950) begin
      logic cal;
      cal = ($urandom_range(0, 3) != 0);
      sample_q.push_back(random_sample(cal));
      n_stim++;
      if (n_stim == 300) begin
        wait (sample_q.size() < 20);
        hold_req = 1'b1;
        wait (hold_cycles != 0);
        hold_req = 1'b0;
      end
      if (n_stim == 800) begin
        wait (sample_q.size() == 0);
        calm = 1'b1;
      end
    end

    wait (sample_q.size() == 0 && !s_axis_tvalid);
    wait (angles_q.size() == 0);
    repeat (400) @(posedge clk);

    $display("Sent %0d sample items, checked %0d result items, %0d calibrations completed.",
             n_sent, n_results, n_cal_done);
    if (n_errors == 0 && angles_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* accel_tilt_angles_with_offset_cal.f */
src/atilt_pkg.sv
src/accel_tilt_angles_with_offset_cal.sv
src/atilt_checker.sv
tb/tb.sv
